// ===== sv/extended_gcd_bezout_top_macros.svh =====
// assertion helpers used by the top-level rtl file
// every macro samples on the rising edge of clk and is off while rst_n is low
`ifndef EXTENDED_GCD_BEZOUT_TOP_MACROS_SVH
`define EXTENDED_GCD_BEZOUT_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define EGB_ASSERT_NOW(label, cond, consq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (consq)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define EGB_ASSERT_NEXT(label, cond, consq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consq)) \
    else $error(msg);

`endif

// ===== sv/egb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package egb_pkg;

  // operand width, coefficients carry two more bits
  localparam int DATA_WIDTH     = 32;
  localparam int COEFF_WIDTH    = DATA_WIDTH + 2;

  // divider bit counter
  localparam int CNT_WIDTH      = $clog2(DATA_WIDTH);

  // stream word widths, padded to whole bytes
  localparam int IN_DATA_WIDTH  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_WIDTH = ((DATA_WIDTH + 2 * COEFF_WIDTH + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== sv/extended_gcd_bezout_top.sv =====
// channel   ports                        word contents (lowest bit up)
// -------   --------------------------   ------------------------------------------
// input     in_tvalid/in_tready/in_tdata value_n, value_k
// output    out_tvalid/out_tready/       tdata: divisor_g, coeff_a, coeff_b, zero pad
//           out_tdata/out_tuser          tuser: zero_divisor
//
// one operand pair at a time; each euclid step is a DATA_WIDTH-bit division
// (restoring divider, one quotient bit a cycle, plus one coefficient update);
// a zero k skips the divider and goes straight to the output stage
// the output register is separate, so a new pair is taken while a result waits
// reset is synchronous, active low, and clears the sequencer and output valid
`timescale 1ns / 1ps
`default_nettype none
`include "extended_gcd_bezout_top_macros.svh"

module extended_gcd_bezout_top
  import egb_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [IN_DATA_WIDTH-1:0]  in_tdata,   // value_n, value_k
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [OUT_DATA_WIDTH-1:0]      out_tdata,  // divisor_g, coeff_a, coeff_b, pad
  output logic                           out_tuser   // zero_divisor
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam int W  = DATA_WIDTH;
  localparam int CW = COEFF_WIDTH;

  // control state
  logic [1:0]           state_r, state_nxt;
  logic [CNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // euclid operands as magnitude and sign, divider remainder
  logic [W-1:0]         nmag_r, nmag_nxt;
  logic [W-1:0]         kmag_r, kmag_nxt;
  logic [W-1:0]         rem_r, rem_nxt;
  logic                 nneg_r, nneg_nxt;
  logic                 kneg_r, kneg_nxt;
  logic                 zf_r, zf_nxt;

  // running coefficient matrix and |q| products
  logic [CW-1:0]        x00_r, x00_nxt;
  logic [CW-1:0]        x01_r, x01_nxt;
  logic [CW-1:0]        x10_r, x10_nxt;
  logic [CW-1:0]        x11_r, x11_nxt;
  logic [CW-1:0]        acc0_r, acc0_nxt;
  logic [CW-1:0]        acc1_r, acc1_nxt;

  // output register
  logic [OUT_DATA_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                      out_user_r, out_user_nxt;

  // datapath signals
  logic [W-1:0]  in_n;
  logic [W-1:0]  in_k;
  logic          in_acc;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;
  logic          qneg;
  logic [CW-1:0] t0;
  logic [CW-1:0] t1;
  logic [W-1:0]  g_val;

  assign in_n      = in_tdata[W-1:0];
  assign in_k      = in_tdata[2*W-1:W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // one restoring division step on the magnitudes
  assign trial = {rem_r, nmag_r[W-1]};
  assign diff  = trial - {1'b0, kmag_r};
  assign ge    = (trial >= {1'b0, kmag_r});

  // x - q*y with q = +/- |q|, |q|*y held in the accumulators
  assign qneg = nneg_r ^ kneg_r;
  assign t0   = qneg ? (x00_r + acc0_r) : (x00_r - acc0_r);
  assign t1   = qneg ? (x10_r + acc1_r) : (x10_r - acc1_r);

  // signed divisor back from magnitude and sign
  assign g_val = kneg_r ? (~kmag_r + W'(1)) : kmag_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    nmag_nxt      = nmag_r;
    kmag_nxt      = kmag_r;
    rem_nxt       = rem_r;
    nneg_nxt      = nneg_r;
    kneg_nxt      = kneg_r;
    zf_nxt        = zf_r;
    x00_nxt       = x00_r;
    x01_nxt       = x01_r;
    x10_nxt       = x10_r;
    x11_nxt       = x11_r;
    acc0_nxt      = acc0_r;
    acc1_nxt      = acc1_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    // the consumer takes the waiting word
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          nmag_nxt = in_n[W-1] ? (~in_n + W'(1)) : in_n;
          kmag_nxt = in_k[W-1] ? (~in_k + W'(1)) : in_k;
          nneg_nxt = in_n[W-1];
          kneg_nxt = in_k[W-1];
          rem_nxt  = '0;
          cnt_nxt  = '0;
          acc0_nxt = '0;
          acc1_nxt = '0;
          x01_nxt  = '0;
          x10_nxt  = '0;
          if (in_k == '0) begin
            // zero divisor: flag with all-zero results
            zf_nxt    = 1'b1;
            x00_nxt   = '0;
            kneg_nxt  = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            zf_nxt    = 1'b0;
            x00_nxt   = CW'(1);
            x11_nxt   = CW'(1);
            state_nxt = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        // quotient bit into the dividend register, horner products alongside
        rem_nxt  = ge ? diff[W-1:0] : trial[W-1:0];
        nmag_nxt = {nmag_r[W-2:0], ge};
        acc0_nxt = {acc0_r[CW-2:0], 1'b0} + (ge ? x01_r : '0);
        acc1_nxt = {acc1_r[CW-2:0], 1'b0} + (ge ? x11_r : '0);
        cnt_nxt  = cnt_r + CNT_WIDTH'(1);
        if (cnt_r == CNT_WIDTH'(W - 1)) begin
          state_nxt = ST_UPD;
        end
      end

      ST_UPD: begin
        if (rem_r == '0) begin
          // last pair: apply the closing vector (1, 1 - q)
          x00_nxt   = t0 + x01_r;
          x10_nxt   = t1 + x11_r;
          state_nxt = ST_FIN;
        end else begin
          // shift the chain and fold this quotient into the matrix
          x00_nxt   = x01_r;
          x01_nxt   = t0;
          x10_nxt   = x11_r;
          x11_nxt   = t1;
          nmag_nxt  = kmag_r;
          nneg_nxt  = kneg_r;
          kmag_nxt  = rem_r;
          kneg_nxt  = nneg_r;
          rem_nxt   = '0;
          acc0_nxt  = '0;
          acc1_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end

      ST_FIN: begin
        // load the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = OUT_DATA_WIDTH'({x10_r, x00_r, g_val});
          out_user_nxt  = zf_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    nmag_r     <= nmag_nxt;
    kmag_r     <= kmag_nxt;
    rem_r      <= rem_nxt;
    nneg_r     <= nneg_nxt;
    kneg_r     <= kneg_nxt;
    zf_r       <= zf_nxt;
    x00_r      <= x00_nxt;
    x01_r      <= x01_nxt;
    x10_r      <= x10_nxt;
    x11_r      <= x11_nxt;
    acc0_r     <= acc0_nxt;
    acc1_r     <= acc1_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // checks on the sequencer and divider
  `EGB_ASSERT_NEXT(a_zero_k_flag, in_acc && (in_k == '0),
                   (state_r == ST_FIN) && zf_r, "zero k not flagged")
  `EGB_ASSERT_NOW(a_div_nonzero, state_r == ST_DIV, kmag_r != '0, "divide by zero magnitude")
  `EGB_ASSERT_NOW(a_rem_bound, (state_r == ST_DIV) || (state_r == ST_UPD),
                  rem_r < kmag_r, "remainder not below divisor")
  `EGB_ASSERT_NEXT(a_fin_hold, (state_r == ST_FIN) && out_valid_r && !out_tready,
                   state_r == ST_FIN, "result overwrote a waiting word")

endmodule

`default_nettype wire
